### hw/rtl/qbc_pkg.sv
// shared constants and types for the quad back-face cull block
package qbc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int NUM_VERTS       = 4;
    localparam int NUM_AXES        = 3;
    localparam int APB_ADDR_W      = 4;
    localparam int APB_DATA_W      = 32;

    typedef enum logic [1:0] {
        REG_CAMERA_X = 2'd0,
        REG_CAMERA_Y = 2'd1,
        REG_CAMERA_Z = 2'd2
    } t_reg_idx;

endpackage

### hw/rtl/qbc_newell.sv
// newell normal and doubled view vector, three pipeline stages
module qbc_newell import qbc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_x [NUM_VERTS],
    input  logic signed [COORD_WIDTH-1:0] i_y [NUM_VERTS],
    input  logic signed [COORD_WIDTH-1:0] i_z [NUM_VERTS],
    input  logic signed [COORD_WIDTH-1:0] i_cam_x,
    input  logic signed [COORD_WIDTH-1:0] i_cam_y,
    input  logic signed [COORD_WIDTH-1:0] i_cam_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [2*COORD_WIDTH+3:0] o_n [NUM_AXES],
    output logic signed [COORD_WIDTH+1:0]   o_v [NUM_AXES]
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int NW = 2 * COORD_WIDTH + 4;
    localparam int VW = COORD_WIDTH + 2;

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    // stage 1: edge differences and sums
    logic signed [DW-1:0] r_dy [NUM_VERTS];
    logic signed [DW-1:0] r_sz [NUM_VERTS];
    logic signed [DW-1:0] r_dz [NUM_VERTS];
    logic signed [DW-1:0] r_sx [NUM_VERTS];
    logic signed [DW-1:0] r_dx [NUM_VERTS];
    logic signed [DW-1:0] r_sy [NUM_VERTS];
    logic signed [VW-1:0] r_v_s1 [NUM_AXES];

    // stage 2: edge products
    logic signed [PW-1:0] r_px [NUM_VERTS];
    logic signed [PW-1:0] r_py [NUM_VERTS];
    logic signed [PW-1:0] r_pz [NUM_VERTS];
    logic signed [VW-1:0] r_v_s2 [NUM_AXES];

    // stage 3: normal
    logic signed [NW-1:0] r_n [NUM_AXES];
    logic signed [VW-1:0] r_v_s3 [NUM_AXES];

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    for (genvar gi = 0; gi < NUM_VERTS; gi++) begin : g_edge
        localparam int J = (gi + 1) % NUM_VERTS;
        always_ff @(posedge i_clk) begin
            if (en1) begin
                r_dy[gi] <= DW'(i_y[gi]) - DW'(i_y[J]);
                r_sz[gi] <= DW'(i_z[gi]) + DW'(i_z[J]);
                r_dz[gi] <= DW'(i_z[gi]) - DW'(i_z[J]);
                r_sx[gi] <= DW'(i_x[gi]) + DW'(i_x[J]);
                r_dx[gi] <= DW'(i_x[gi]) - DW'(i_x[J]);
                r_sy[gi] <= DW'(i_y[gi]) + DW'(i_y[J]);
            end
            if (en2) begin
                r_px[gi] <= r_dy[gi] * r_sz[gi];
                r_py[gi] <= r_dz[gi] * r_sx[gi];
                r_pz[gi] <= r_dx[gi] * r_sy[gi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            // view vector doubled to midpoint of v0-v2
            r_v_s1[0] <= VW'(i_x[0]) + VW'(i_x[2]) - (VW'(i_cam_x) <<< 1);
            r_v_s1[1] <= VW'(i_y[0]) + VW'(i_y[2]) - (VW'(i_cam_y) <<< 1);
            r_v_s1[2] <= VW'(i_z[0]) + VW'(i_z[2]) - (VW'(i_cam_z) <<< 1);
        end
        if (en2) begin
            r_v_s2 <= r_v_s1;
        end
        if (en3) begin
            r_n[0] <= NW'(r_px[0]) + NW'(r_px[1]) + NW'(r_px[2]) + NW'(r_px[3]);
            r_n[1] <= NW'(r_py[0]) + NW'(r_py[1]) + NW'(r_py[2]) + NW'(r_py[3]);
            r_n[2] <= NW'(r_pz[0]) + NW'(r_pz[1]) + NW'(r_pz[2]) + NW'(r_pz[3]);
            r_v_s3 <= r_v_s2;
        end
    end

    assign o_n = r_n;
    assign o_v = r_v_s3;

endmodule

### hw/rtl/qbc_dot.sv
// split dot product of normal and view vector, sign test, output register
module qbc_dot import qbc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [2*COORD_WIDTH+3:0] i_n [NUM_AXES],
    input  logic signed [COORD_WIDTH+1:0]   i_v [NUM_AXES],
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_keep_face
);

    localparam int NW   = 2 * COORD_WIDTH + 4;
    localparam int VW   = COORD_WIDTH + 2;
    localparam int K    = VW;
    localparam int HW   = NW - K;
    localparam int PLW  = K + 1 + VW;
    localparam int PHW  = HW + VW;
    localparam int SLW  = PLW + 2;
    localparam int SHW  = PHW + 2;
    localparam int DOTW = SHW + K;

    logic r_v4, r_v5, r_v6;
    logic en4, en5, en6;

    logic signed [PLW-1:0]  r_pl [NUM_AXES];
    logic signed [PHW-1:0]  r_ph [NUM_AXES];
    logic signed [SLW-1:0]  r_sl;
    logic signed [SHW-1:0]  r_sh;
    logic signed [DOTW-1:0] n_dot;
    logic                   r_keep;

    assign en6     = !r_v6 || i_ready;
    assign en5     = !r_v5 || en6;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;
    assign o_valid = r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // normal split into unsigned low and signed high halves
    for (genvar gc = 0; gc < NUM_AXES; gc++) begin : g_axis
        always_ff @(posedge i_clk) begin
            if (en4) begin
                r_pl[gc] <= $signed({1'b0, i_n[gc][K-1:0]}) * i_v[gc];
                r_ph[gc] <= $signed(i_n[gc][NW-1:K]) * i_v[gc];
            end
        end
    end

    assign n_dot = (DOTW'(r_sh) <<< K) + DOTW'(r_sl);

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_sl <= SLW'(r_pl[0]) + SLW'(r_pl[1]) + SLW'(r_pl[2]);
            r_sh <= SHW'(r_ph[0]) + SHW'(r_ph[1]) + SHW'(r_ph[2]);
        end
        if (en6) begin
            // keep unless strictly positive
            r_keep <= n_dot[DOTW-1] || (n_dot == '0);
        end
    end

    assign o_keep_face = r_keep;

endmodule

### hw/rtl/quad_backface_cull.sv
// top level of the quad back-face cull block with camera registers
//
// One transaction on the input channel (i_valid / o_ready) carries a quad as
// four vertices v0..v3 in winding order. One transaction on the output channel
// (o_valid / i_ready) returns o_keep_face: 1 keeps a front-facing or edge-on
// face, 0 culls a back-facing one.
// The camera position is written through the APB port: camera_x at 0x0,
// camera_y at 0x4, camera_z at 0x8; write only while the block is idle.
// The result passes through six register stages (edge sums, edge products,
// normal sum, split dot products, partial sums, final add with sign test).
// Throughput is one quad per cycle while the receiver takes results: each
// stage takes a new quad per cycle unless it is full and cannot pass its quad on.
// Each stage has its own valid bit and advances when it is empty or the next
// stage moves, so when the receiver stalls the result holds in the output
// register and upstream stages keep filling until the pipeline is full.
// Reset clears all valid bits and the camera registers to zero.
module quad_backface_cull import qbc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_v0_x,
    input  logic signed [COORD_WIDTH-1:0] i_v0_y,
    input  logic signed [COORD_WIDTH-1:0] i_v0_z,
    input  logic signed [COORD_WIDTH-1:0] i_v1_x,
    input  logic signed [COORD_WIDTH-1:0] i_v1_y,
    input  logic signed [COORD_WIDTH-1:0] i_v1_z,
    input  logic signed [COORD_WIDTH-1:0] i_v2_x,
    input  logic signed [COORD_WIDTH-1:0] i_v2_y,
    input  logic signed [COORD_WIDTH-1:0] i_v2_z,
    input  logic signed [COORD_WIDTH-1:0] i_v3_x,
    input  logic signed [COORD_WIDTH-1:0] i_v3_y,
    input  logic signed [COORD_WIDTH-1:0] i_v3_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_keep_face
);

    localparam int NW = 2 * COORD_WIDTH + 4;
    localparam int VW = COORD_WIDTH + 2;

    logic signed [COORD_WIDTH-1:0] r_cam_x, r_cam_y, r_cam_z;
    logic                          cfg_wr;
    logic [1:0]                    cfg_idx;

    logic signed [COORD_WIDTH-1:0] vx [NUM_VERTS];
    logic signed [COORD_WIDTH-1:0] vy [NUM_VERTS];
    logic signed [COORD_WIDTH-1:0] vz [NUM_VERTS];

    logic                 nw_valid, nw_ready;
    logic signed [NW-1:0] nw_n [NUM_AXES];
    logic signed [VW-1:0] nw_v [NUM_AXES];

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CAMERA_X: r_cam_x <= pwdata[COORD_WIDTH-1:0];
                REG_CAMERA_Y: r_cam_y <= pwdata[COORD_WIDTH-1:0];
                REG_CAMERA_Z: r_cam_z <= pwdata[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_CAMERA_X: prdata = APB_DATA_W'(r_cam_x);
            REG_CAMERA_Y: prdata = APB_DATA_W'(r_cam_y);
            REG_CAMERA_Z: prdata = APB_DATA_W'(r_cam_z);
            default:      prdata = '0;
        endcase
    end

    assign vx[0] = i_v0_x;
    assign vy[0] = i_v0_y;
    assign vz[0] = i_v0_z;
    assign vx[1] = i_v1_x;
    assign vy[1] = i_v1_y;
    assign vz[1] = i_v1_z;
    assign vx[2] = i_v2_x;
    assign vy[2] = i_v2_y;
    assign vz[2] = i_v2_z;
    assign vx[3] = i_v3_x;
    assign vy[3] = i_v3_y;
    assign vz[3] = i_v3_z;

    qbc_newell #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_newell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_x     (vx),
        .i_y     (vy),
        .i_z     (vz),
        .i_cam_x (r_cam_x),
        .i_cam_y (r_cam_y),
        .i_cam_z (r_cam_z),
        .o_valid (nw_valid),
        .i_ready (nw_ready),
        .o_n     (nw_n),
        .o_v     (nw_v)
    );

    qbc_dot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (nw_valid),
        .o_ready     (nw_ready),
        .i_n         (nw_n),
        .i_v         (nw_v),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_keep_face (o_keep_face)
    );

endmodule

### bench/quad_backface_cull_tb.sv
// self-checking testbench for the quad back-face cull block with its camera registers
`timescale 1ns / 100ps

import qbc_pkg::*;

typedef logic signed [COORD_WIDTH_DEF-1:0] t_coord;
typedef t_coord [0:NUM_AXES-1] t_vertex;
typedef t_vertex [0:NUM_VERTS-1] t_quad;
typedef logic signed [127:0] t_wide;

class keep_face_scoreboard;
    t_vertex     camera;
    bit          pending_keeps[$];
    int unsigned n_checked;
    int unsigned n_culled;
    int unsigned n_mismatch;
    int unsigned n_reg_writes;

    function new();
        camera = '0;
    endfunction

    function void write_camera(int idx, logic [APB_DATA_W-1:0] data);
        n_reg_writes++;
        case (idx)
            REG_CAMERA_X: camera[0] = data[COORD_WIDTH_DEF-1:0];
            REG_CAMERA_Y: camera[1] = data[COORD_WIDTH_DEF-1:0];
            REG_CAMERA_Z: camera[2] = data[COORD_WIDTH_DEF-1:0];
            default: ;
        endcase
    endfunction

    // newell normal dotted with the doubled view vector, exact in 128 bits
    function bit face_keep(t_quad q);
        t_wide p[NUM_VERTS][NUM_AXES];
        t_wide n[NUM_AXES];
        t_wide cam;
        t_wide view;
        t_wide dot;
        int    j;
        for (int i = 0; i < NUM_VERTS; i++)
            for (int a = 0; a < NUM_AXES; a++)
                p[i][a] = $signed(q[i][a]);
        for (int a = 0; a < NUM_AXES; a++)
            n[a] = 0;
        for (int i = 0; i < NUM_VERTS; i++) begin
            j = (i + 1) % NUM_VERTS;
            n[0] += (p[i][1] - p[j][1]) * (p[i][2] + p[j][2]);
            n[1] += (p[i][2] - p[j][2]) * (p[i][0] + p[j][0]);
            n[2] += (p[i][0] - p[j][0]) * (p[i][1] + p[j][1]);
        end
        dot = 0;
        for (int a = 0; a < NUM_AXES; a++) begin
            cam  = $signed(camera[a]);
            view = p[0][a] + p[2][a] - 2 * cam;
            dot += n[a] * view;
        end
        return !(dot > 0);
    endfunction

    function void note_quad(t_quad q);
        pending_keeps = {pending_keeps, face_keep(q)};
    endfunction

    function void check_keep(logic got);
        bit want;
        if (pending_keeps.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("unexpected keep_face transaction, got %0b", got);
            return;
        end
        want = pending_keeps.pop_front();
        n_checked++;
        if (!want)
            n_culled++;
        if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("keep_face mismatch on result %0d: expected %0b, got %0b",
                         n_checked, want, got);
        end
    endfunction

    function int pending();
        return pending_keeps.size();
    endfunction

    function int unsigned failures();
        return n_mismatch + pending_keeps.size();
    endfunction
endclass

module quad_backface_cull_tb;

    localparam int COORD_MAX      = (1 << (COORD_WIDTH_DEF - 1)) - 1;
    localparam int COORD_MIN      = -(1 << (COORD_WIDTH_DEF - 1));
    localparam int REG_BYTES      = 4;
    localparam int REG_UNUSED_IDX = 3;
    localparam int RESET_CYCLES   = 6;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 130;
    localparam int HOLD_PHASE     = 3;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int HOLD_BURST     = 60;
    localparam int DRAIN_CYCLES   = 12;
    localparam int QUIET_LIMIT    = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid;
    logic                  o_ready;
    t_coord                i_v0_x, i_v0_y, i_v0_z;
    t_coord                i_v1_x, i_v1_y, i_v1_z;
    t_coord                i_v2_x, i_v2_y, i_v2_z;
    t_coord                i_v3_x, i_v3_y, i_v3_z;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_keep_face;

    bit                    tx_steady;
    bit                    rx_steady;
    bit                    rx_hold_req;
    bit                    rx_holding;
    int unsigned           quiet_cycles;
    keep_face_scoreboard   sb = new();

    quad_backface_cull #(.COORD_WIDTH(COORD_WIDTH_DEF)) u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_quad({i_v0_x, i_v0_y, i_v0_z, i_v1_x, i_v1_y, i_v1_z,
                              i_v2_x, i_v2_y, i_v2_z, i_v3_x, i_v3_y, i_v3_z});
            if (o_valid && i_ready)
                sb.check_keep(o_keep_face);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("quad_backface_cull verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random ready bursts, steady stretches and one long hold
    initial begin
        int n;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_req) begin
                i_ready    <= 1'b0;
                rx_holding = 1'b1;
                n          = 0;
                while (n < RX_HOLD_CYCLES) begin
                    @(posedge i_clk);
                    n++;
                end
                rx_holding  = 1'b0;
                rx_hold_req = 1'b0;
            end else if (rx_steady) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0: return t_coord'(COORD_MIN);
            1: return t_coord'(COORD_MAX);
            2: return '0;
            3: return $urandom_range(0, 1) ? t_coord'(1) : t_coord'(-1);
            4, 5: return t_coord'(int'($urandom_range(0, 256)) - 128);
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_quad make_quad(input int v[12]);
        t_quad q;
        for (int i = 0; i < NUM_VERTS; i++)
            for (int a = 0; a < NUM_AXES; a++)
                q[i][a] = t_coord'(v[NUM_AXES * i + a]);
        return q;
    endfunction

    function automatic t_quad next_quad();
        t_quad q;
        int    axis;
        int    c;
        int    delta;
        int    base;
        int    stride;
        int    k[NUM_VERTS];
        for (int i = 0; i < NUM_VERTS; i++)
            k[i] = int'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                for (int i = 0; i < NUM_VERTS; i++)
                    for (int a = 0; a < NUM_AXES; a++)
                        q[i][a] = t_coord'($urandom);
            end
            4, 5: begin
                for (int i = 0; i < NUM_VERTS; i++)
                    for (int a = 0; a < NUM_AXES; a++)
                        q[i][a] = rand_coord();
            end
            6: begin
                // edge-on: the face lies in an axis plane through the camera
                axis = $urandom_range(0, NUM_AXES - 1);
                for (int i = 0; i < NUM_VERTS; i++)
                    for (int a = 0; a < NUM_AXES; a++)
                        q[i][a] = (a == axis) ? sb.camera[a] : rand_coord();
            end
            7: begin
                // collinear vertices give a zero normal
                for (int a = 0; a < NUM_AXES; a++) begin
                    base   = int'($urandom_range(0, 16000)) - 8000;
                    stride = int'($urandom_range(0, 1000)) - 500;
                    for (int i = 0; i < NUM_VERTS; i++)
                        q[i][a] = t_coord'(base + k[i] * stride);
                end
            end
            8: begin
                // diagonal midpoint at the camera gives a zero view vector
                for (int a = 0; a < NUM_AXES; a++) begin
                    c     = $signed(sb.camera[a]);
                    delta = int'($urandom_range(0, 2000)) - 1000;
                    if (c + delta > COORD_MAX || c + delta < COORD_MIN ||
                        c - delta > COORD_MAX || c - delta < COORD_MIN)
                        delta = 0;
                    q[0][a] = t_coord'(c + delta);
                    q[2][a] = t_coord'(c - delta);
                    q[1][a] = t_coord'($urandom);
                    q[3][a] = t_coord'($urandom);
                end
            end
            default: begin
                for (int i = 0; i < NUM_VERTS; i++)
                    for (int a = 0; a < NUM_AXES; a++)
                        q[i][a] = t_coord'(int'($urandom_range(0, 6)) - 3);
            end
        endcase
        return q;
    endfunction

    task automatic send_quad(t_quad q);
        {i_v0_x, i_v0_y, i_v0_z, i_v1_x, i_v1_y, i_v1_z,
         i_v2_x, i_v2_y, i_v2_z, i_v3_x, i_v3_y, i_v3_z} <= q;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic sender_gap(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        sender_gap(1);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * REG_BYTES);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_camera(idx, data);
        @(posedge i_clk);
    endtask

    // upper data bits are random and must be dropped by the register
    task automatic move_camera(t_vertex cam);
        wait_drained();
        for (int a = 0; a < NUM_AXES; a++)
            write_reg(REG_CAMERA_X + a,
                      {(APB_DATA_W - COORD_WIDTH_DEF)'($urandom), cam[a]});
    endtask

    initial begin
        t_quad   dq[12];
        t_vertex cam;
        int      hold_left;
        int      sel_hi[5];
        int      sel_lo[4];

        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        i_valid   <= 1'b0;
        {i_v0_x, i_v0_y, i_v0_z, i_v1_x, i_v1_y, i_v1_z,
         i_v2_x, i_v2_y, i_v2_z, i_v3_x, i_v3_y, i_v3_z} <= '0;
        i_rst_n   <= 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dq[0]  = make_quad('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        dq[1]  = make_quad('{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                             COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
        dq[2]  = make_quad('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                             COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN});
        dq[3]  = make_quad('{-100, -100, -100, 100, -100, -100,
                             100, 100, -100, -100, 100, -100});
        dq[4]  = make_quad('{-100, -100, -100, -100, 100, -100,
                             100, 100, -100, 100, -100, -100});
        dq[5]  = make_quad('{-100, -100, 0, 100, -100, 0, 100, 100, 0, -100, 100, 0});
        dq[6]  = make_quad('{-10, -10, -10, 10, -10, 0, 10, 10, 10, -10, 10, 0});
        dq[7]  = make_quad('{1, 2, 3, 2, 4, 6, 3, 6, 9, 4, 8, 12});
        dq[8]  = make_quad('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                             COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX});
        dq[9]  = make_quad('{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                             COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN});
        dq[10] = make_quad('{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                             COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN});
        dq[11] = make_quad('{COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
                             COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN});
        sel_hi = '{3, 4, 8, 10, 2};
        sel_lo = '{3, 4, 9, 1};

        // camera at its reset position
        for (int k = 0; k < 12; k++)
            send_quad(dq[k]);
        move_camera({NUM_AXES{t_coord'(COORD_MAX)}});
        for (int k = 0; k < 5; k++)
            send_quad(dq[sel_hi[k]]);
        move_camera({NUM_AXES{t_coord'(COORD_MIN)}});
        for (int k = 0; k < 4; k++)
            send_quad(dq[sel_lo[k]]);
        // a write past the last register must leave the camera alone
        wait_drained();
        write_reg(REG_UNUSED_IDX, $urandom);
        send_quad(dq[3]);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: cam = '0;
                1: cam = {NUM_AXES{t_coord'(COORD_MAX)}};
                2: cam = {NUM_AXES{t_coord'(COORD_MIN)}};
                default: begin
                    for (int a = 0; a < NUM_AXES; a++)
                        cam[a] = rand_coord();
                end
            endcase
            move_camera(cam);
            tx_steady = (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
            rx_steady = (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
            hold_left = 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == HOLD_PHASE && k == 10) begin
                    rx_hold_req = 1'b1;
                    sender_gap(1);
                    while (!rx_holding) @(posedge i_clk);
                    hold_left = HOLD_BURST;
                end
                send_quad(next_quad());
                if (hold_left > 0)
                    hold_left--;
                else if (!tx_steady && $urandom_range(0, 5) == 0)
                    sender_gap($urandom_range(1, 18));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0d keep_face results never arrived", sb.pending());
        $display("%0d quads checked, %0d culled and %0d kept, over %0d camera register writes",
                 sb.n_checked, sb.n_culled, sb.n_checked - sb.n_culled, sb.n_reg_writes);
        $display("faces: extreme, edge-on, zero normal, zero view; flow: gaps, hold, full rate");
        if (sb.failures() == 0)
            $display("quad_backface_cull verification clean");
        else
            $display("quad_backface_cull verification failed");
        $finish;
    end

endmodule
